[sv/crs_pkg.sv]
// Shared types and constants of the Catmull-Rom segment sampler.
package crs_pkg;

  localparam int NW = 48;
  localparam int DW = 18;
  localparam int SW = 6;
  localparam int OW = 25;
  localparam int NUM_TERMS = 8;

  localparam logic [SW-1:0] MAX_ROOT  = 6'd49;
  localparam logic [SW-1:0] MIN_STEPS = 6'd2;

  localparam logic signed [NW-1:0] OUT_MAX = 48'sd16777215;
  localparam logic signed [NW-1:0] OUT_MIN = -48'sd16777216;

  typedef struct packed {
    logic signed [NW-1:0] q;
    logic [DW-1:0]        r;
  } term_t;

  typedef struct packed {
    term_t f;
    term_t d1;
    term_t d2;
    term_t d3;
  } coord_t;

  typedef struct packed {
    coord_t        x;
    coord_t        y;
    logic [DW-1:0] den;
    logic [SW-1:0] steps;
  } seg_t;

endpackage

[sv/catmull_rom_segment_sampler.sv]
// Top level of the Catmull-Rom segment sampler.
//
//   channel   direction  handshake               payload
//   in        input      in_valid / in_stall     before, start, end, after, has_*
//   out       output     out_valid / out_stall   point_x, point_y, last
//
// Each segment yields steps+1 samples (3..51), one per cycle from the back end while out is not stalled.
// The front end is busy with each segment until its bit-serial dividers finish;
// the queue lets the next segment be prepared meanwhile.
// Reset is synchronous and clears control state only; no clearing pass.
// A stall on out holds the current sample; in_stall is high while the
// front end is busy.
module catmull_rom_segment_sampler #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [15:0]            before_x,
  input  logic signed [15:0]            before_y,
  input  logic signed [15:0]            start_x,
  input  logic signed [15:0]            start_y,
  input  logic signed [15:0]            end_x,
  input  logic signed [15:0]            end_y,
  input  logic signed [15:0]            after_x,
  input  logic signed [15:0]            after_y,
  input  logic                          has_before,
  input  logic                          has_after,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [crs_pkg::OW-1:0] point_x,
  output logic signed [crs_pkg::OW-1:0] point_y,
  output logic                          last
);

  crs_pkg::seg_t wdata, rdata;
  logic          push, pop, full, empty;

  crs_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .before_x(before_x), .before_y(before_y), .start_x(start_x), .start_y(start_y),
    .end_x(end_x), .end_y(end_y), .after_x(after_x), .after_y(after_y),
    .has_before(has_before), .has_after(has_after),
    .q_full(full), .q_push(push), .q_data(wdata)
  );

  crs_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk(clk), .rst(rst), .push(push), .wdata(wdata), .pop(pop),
    .rdata(rdata), .full(full), .empty(empty)
  );

  crs_back u_back (
    .clk(clk), .rst(rst), .q_empty(empty), .q_data(rdata), .q_pop(pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .point_x(point_x), .point_y(point_y), .last(last)
  );

endmodule

[sv/crs_div.sv]
// Radix-2 floor divider: signed numerator, unsigned divisor, one bit a cycle.
module crs_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [crs_pkg::NW-1:0] num,
  input  logic [crs_pkg::DW-1:0]        den,
  output logic                          done,
  output crs_pkg::term_t                res
);

  logic [crs_pkg::NW-1:0] mag;
  logic [crs_pkg::DW-1:0] racc;
  logic [crs_pkg::DW-1:0] dreg;
  logic                   neg;
  logic                   run;
  logic [5:0]             cnt;
  logic [crs_pkg::DW:0]   trial;

  assign trial = {racc, mag[crs_pkg::NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(crs_pkg::NW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag  <= num[crs_pkg::NW-1] ? crs_pkg::NW'(-num) : num;
      neg  <= num[crs_pkg::NW-1];
      racc <= '0;
      dreg <= den;
    end else if (run) begin
      if (trial >= {1'b0, dreg}) begin
        racc <= crs_pkg::DW'(trial - {1'b0, dreg});
        mag  <= {mag[crs_pkg::NW-2:0], 1'b1};
      end else begin
        racc <= trial[crs_pkg::DW-1:0];
        mag  <= {mag[crs_pkg::NW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (neg && racc != '0) begin
      res.q = $signed(~mag);
      res.r = dreg - racc;
    end else if (neg) begin
      res.q = $signed(-mag);
      res.r = racc;
    end else begin
      res.q = $signed(mag);
      res.r = racc;
    end
  end

endmodule

[sv/crs_front.sv]
// Front end: takes a segment, finds the step count and the difference terms.
module crs_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] before_x,
  input  logic signed [15:0] before_y,
  input  logic signed [15:0] start_x,
  input  logic signed [15:0] start_y,
  input  logic signed [15:0] end_x,
  input  logic signed [15:0] end_y,
  input  logic signed [15:0] after_x,
  input  logic signed [15:0] after_y,
  input  logic               has_before,
  input  logic               has_after,
  input  logic               q_full,
  output logic               q_push,
  output crs_pkg::seg_t      q_data
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DIST  = 4'd1;
  localparam logic [3:0] ST_ROOT  = 4'd2;
  localparam logic [3:0] ST_STEP  = 4'd3;
  localparam logic [3:0] ST_SQ    = 4'd4;
  localparam logic [3:0] ST_MUL   = 4'd5;
  localparam logic [3:0] ST_P1    = 4'd6;
  localparam logic [3:0] ST_START = 4'd7;
  localparam logic [3:0] ST_DIV   = 4'd8;
  localparam logic [3:0] ST_PUSH  = 4'd9;

  logic [3:0] state;

  logic signed [15:0] p0x, p1x, p2x, p3x, p0y, p1y, p2y, p3y;
  logic               linear;
  logic signed [19:0] ax, bx, cx, ay, by, cy;
  logic [31:0]        dxs, dys;
  logic [5:0]         r;
  logic [2:0]         rb;
  logic [5:0]         s;
  logic [11:0]        s2;
  logic [16:0]        s3;
  logic signed [32:0] max_a, may_a;
  logic signed [26:0] mbx, mby;
  logic signed [33:0] m0x, m0y;
  logic [crs_pkg::DW-1:0]        den;
  logic signed [crs_pkg::NW-1:0] dnum [crs_pkg::NUM_TERMS];
  logic                          div_start;
  logic [crs_pkg::NUM_TERMS-1:0] div_done;
  crs_pkg::term_t                dres [crs_pkg::NUM_TERMS];

  // Coefficients from the substituted points
  function automatic logic signed [59:0] coefs(
    input logic signed [15:0] p0, input logic signed [15:0] p1,
    input logic signed [15:0] p2, input logic signed [15:0] p3, input logic lin);
    logic signed [19:0] e0, e1, e2, e3, a, b, c;
    e0 = 20'(p0);
    e1 = 20'(p1);
    e2 = 20'(p2);
    e3 = 20'(p3);
    if (lin) begin
      a = 20'(2) * (e2 - e1);
      b = '0;
      c = '0;
    end else begin
      a = e2 - e0;
      b = 20'(2) * e0 - 20'(5) * e1 + 20'(4) * e2 - e3;
      c = -e0 + 20'(3) * e1 - 20'(3) * e2 + e3;
    end
    return {a, b, c};
  endfunction

  // f0, d1, d2, d3 of 256*n(i) + s3
  function automatic logic signed [4*crs_pkg::NW-1:0] diffs(
    input logic signed [33:0] m0, input logic signed [32:0] ma,
    input logic signed [26:0] mb, input logic signed [19:0] c,
    input logic [16:0] cube);
    logic signed [crs_pkg::NW-1:0] a0, a1, a2, a3, f0, d1, d2, d3;
    a0 = crs_pkg::NW'(m0) <<< 1;
    a1 = crs_pkg::NW'(ma);
    a2 = crs_pkg::NW'(mb);
    a3 = crs_pkg::NW'(c);
    f0 = (a0 <<< 8) + $signed({31'b0, cube});
    d1 = (a1 + a2 + a3) <<< 8;
    d2 = ((a2 <<< 1) + (a3 <<< 2) + (a3 <<< 1)) <<< 8;
    d3 = ((a3 <<< 2) + (a3 <<< 1)) <<< 8;
    return {f0, d1, d2, d3};
  endfunction

  logic signed [16:0] dx, dy;
  logic signed [33:0] dx_sq, dy_sq;
  logic [34:0]        qsq;
  logic [5:0]         cand;
  logic [11:0]        cand_sq;
  logic [5:0]         rc;
  logic [5:0]         rs;

  assign dx      = 17'(p2x) - 17'(p1x);
  assign dy      = 17'(p2y) - 17'(p1y);
  assign dx_sq   = dx * dx;
  assign dy_sq   = dy * dy;
  assign qsq     = {{1'b0, dxs} + {1'b0, dys}, 2'b00};
  assign cand    = r | (6'd1 << rb);
  assign cand_sq = 12'(cand * cand);
  assign rc      = (r > crs_pkg::MAX_ROOT) ? crs_pkg::MAX_ROOT : r;
  assign rs      = rc + 6'd1;

  assign in_stall = (state != ST_IDLE);
  assign q_push   = (state == ST_PUSH) && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      case (state)
        ST_IDLE:  if (in_valid) state <= ST_DIST;
        ST_DIST:  state <= ST_ROOT;
        ST_ROOT:  if (rb == 3'd0) state <= ST_STEP;
        ST_STEP:  state <= ST_SQ;
        ST_SQ:    state <= ST_MUL;
        ST_MUL:   state <= ST_P1;
        ST_P1:    state <= ST_START;
        ST_START: begin
          div_start <= 1'b1;
          state     <= ST_DIV;
        end
        ST_DIV:   if (div_done[0]) state <= ST_PUSH;
        ST_PUSH:  if (!q_full) state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        p0x    <= has_before ? before_x : start_x;
        p0y    <= has_before ? before_y : start_y;
        p1x    <= start_x;
        p1y    <= start_y;
        p2x    <= end_x;
        p2y    <= end_y;
        p3x    <= has_after ? after_x : end_x;
        p3y    <= has_after ? after_y : end_y;
        linear <= !has_before && !has_after;
      end
      ST_DIST: begin
        dxs          <= dx_sq[31:0];
        dys          <= dy_sq[31:0];
        {ax, bx, cx} <= coefs(p0x, p1x, p2x, p3x, linear);
        {ay, by, cy} <= coefs(p0y, p1y, p2y, p3y, linear);
        r            <= '0;
        rb           <= 3'd5;
      end
      ST_ROOT: begin
        if ({23'b0, cand_sq} <= qsq) r <= cand;
        rb <= rb - 3'd1;
      end
      ST_STEP: s <= (rs < crs_pkg::MIN_STEPS) ? crs_pkg::MIN_STEPS : rs;
      ST_SQ:   s2 <= 12'(s * s);
      ST_MUL: begin
        s3    <= 17'(s2 * s);
        max_a <= 33'(ax * $signed({1'b0, s2}));
        may_a <= 33'(ay * $signed({1'b0, s2}));
        mbx   <= 27'(bx * $signed({1'b0, s}));
        mby   <= 27'(by * $signed({1'b0, s}));
      end
      ST_P1: begin
        m0x <= 34'(p1x * $signed({1'b0, s3}));
        m0y <= 34'(p1y * $signed({1'b0, s3}));
      end
      ST_START: begin
        den <= {s3, 1'b0};
        {dnum[0], dnum[1], dnum[2], dnum[3]} <= diffs(m0x, max_a, mbx, cx, s3);
        {dnum[4], dnum[5], dnum[6], dnum[7]} <= diffs(m0y, may_a, mby, cy, s3);
      end
      default: ;
    endcase
  end

  for (genvar g = 0; g < crs_pkg::NUM_TERMS; g++) begin : g_div
    crs_div u_div (
      .clk   (clk),
      .rst   (rst),
      .start (div_start),
      .num   (dnum[g]),
      .den   (den),
      .done  (div_done[g]),
      .res   (dres[g])
    );
  end

  assign q_data.x     = '{f: dres[0], d1: dres[1], d2: dres[2], d3: dres[3]};
  assign q_data.y     = '{f: dres[4], d1: dres[5], d2: dres[6], d3: dres[7]};
  assign q_data.den   = den;
  assign q_data.steps = s;

  a_push_state: assert property (@(posedge clk) disable iff (rst)
    q_push |=> state == ST_IDLE) else $error("push did not free the front");
  a_done_agree: assert property (@(posedge clk) disable iff (rst)
    div_done[0] |-> div_done == '1) else $error("dividers out of step");
  a_root_steps: assert property (@(posedge clk) disable iff (rst)
    state == ST_SQ |-> s >= crs_pkg::MIN_STEPS && s <= 6'd50) else $error("bad step count");

endmodule

[sv/crs_fifo.sv]
// Segment queue between front and back ends.
module crs_fifo #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  crs_pkg::seg_t wdata,
  input  logic          pop,
  output crs_pkg::seg_t rdata,
  output logic          full,
  output logic          empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  crs_pkg::seg_t     mem [DEPTH];
  logic [AW-1:0]     wptr, rptr;
  logic [AW:0]       count;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      if (pop)  rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

endmodule

[sv/crs_back.sv]
// Back end: steps the forward differences and emits one sample a cycle while out is not stalled.
module crs_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  crs_pkg::seg_t                 q_data,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [crs_pkg::OW-1:0] point_x,
  output logic signed [crs_pkg::OW-1:0] point_y,
  output logic                          last
);

  crs_pkg::coord_t        cx, cy;
  logic [crs_pkg::DW-1:0] den;
  logic [crs_pkg::SW-1:0] steps;
  logic [crs_pkg::SW-1:0] idx;
  logic                   busy;
  logic                   adv;

  function automatic crs_pkg::term_t add_term(input crs_pkg::term_t v,
                                              input crs_pkg::term_t d,
                                              input logic [crs_pkg::DW-1:0] dv);
    crs_pkg::term_t       o;
    logic [crs_pkg::DW:0] rsum;
    rsum = {1'b0, v.r} + {1'b0, d.r};
    if (rsum >= {1'b0, dv}) begin
      o.r = crs_pkg::DW'(rsum - {1'b0, dv});
      o.q = v.q + d.q + crs_pkg::NW'(1);
    end else begin
      o.r = rsum[crs_pkg::DW-1:0];
      o.q = v.q + d.q;
    end
    return o;
  endfunction

  function automatic crs_pkg::coord_t advance(input crs_pkg::coord_t c,
                                              input logic [crs_pkg::DW-1:0] dv);
    crs_pkg::coord_t o;
    o.f  = add_term(c.f, c.d1, dv);
    o.d1 = add_term(c.d1, c.d2, dv);
    o.d2 = add_term(c.d2, c.d3, dv);
    o.d3 = c.d3;
    return o;
  endfunction

  function automatic logic signed [crs_pkg::OW-1:0] sat(input logic signed [crs_pkg::NW-1:0] v);
    if (v > crs_pkg::OUT_MAX) return crs_pkg::OW'(crs_pkg::OUT_MAX);
    if (v < crs_pkg::OUT_MIN) return crs_pkg::OW'(crs_pkg::OUT_MIN);
    return crs_pkg::OW'(v);
  endfunction

  assign q_pop = !busy && !q_empty;
  assign adv   = busy && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) busy <= 1'b1;
      else if (adv && idx == steps) busy <= 1'b0;
      if (adv) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cx    <= q_data.x;
      cy    <= q_data.y;
      den   <= q_data.den;
      steps <= q_data.steps;
      idx   <= '0;
    end else if (adv) begin
      point_x <= sat(cx.f.q);
      point_y <= sat(cy.f.q);
      last    <= (idx == steps);
      cx      <= advance(cx, den);
      cy      <= advance(cy, den);
      idx     <= idx + crs_pkg::SW'(1);
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx <= steps) else $error("sample index past step count");
  a_end_seg: assert property (@(posedge clk) disable iff (rst)
    (adv && idx == steps) |=> !busy && last) else $error("segment did not close");
  a_load: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> busy && idx == '0) else $error("load lost");

endmodule

[test/crs_checker.sv]
// Checker for the Catmull-Rom segment sampler: predicts samples and compares.
module crs_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] before_x,
  input  logic signed [15:0] before_y,
  input  logic signed [15:0] start_x,
  input  logic signed [15:0] start_y,
  input  logic signed [15:0] end_x,
  input  logic signed [15:0] end_y,
  input  logic signed [15:0] after_x,
  input  logic signed [15:0] after_y,
  input  logic               has_before,
  input  logic               has_after,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [24:0] point_x,
  input  logic signed [24:0] point_y,
  input  logic               last,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [24:0] x;
    logic signed [24:0] y;
    logic               fin;
  } sample_t;

  sample_t expected_samples[$];

  assign pending = expected_samples.size();

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic logic signed [24:0] sat25(longint v);
    if (v > 16777215) v = 16777215;
    if (v < -16777216) v = -16777216;
    return v[24:0];
  endfunction

  function automatic logic signed [24:0] spline_coord(longint p0, longint p1, longint p2,
                                                      longint p3, bit lin, longint i,
                                                      longint s);
    longint s3, n;
    s3 = s * s * s;
    if (lin) return sat25(floor_quot(512 * (p1 * s + (p2 - p1) * i) + s, 2 * s));
    n = 2 * p1 * s3 + (p2 - p0) * i * s * s + (2 * p0 - 5 * p1 + 4 * p2 - p3) * i * i * s
        + (-p0 + 3 * p1 - 3 * p2 + p3) * i * i * i;
    return sat25(floor_quot(256 * n + s3, 2 * s3));
  endfunction

  task automatic predict_segment();
    longint dx, dy, q, r, s, bx, by, ax, ay;
    bit lin;
    sample_t e;
    dx = longint'(end_x) - start_x;
    dy = longint'(end_y) - start_y;
    q = 4 * (dx * dx + dy * dy);
    r = 0;
    while (r < 49 && (r + 1) * (r + 1) <= q) r++;
    s = r + 1;
    if (s < 2) s = 2;
    bx = has_before ? before_x : start_x;
    by = has_before ? before_y : start_y;
    ax = has_after ? after_x : end_x;
    ay = has_after ? after_y : end_y;
    lin = !has_before && !has_after;
    for (longint i = 0; i <= s; i++) begin
      e.x = spline_coord(bx, start_x, end_x, ax, lin, i, s);
      e.y = spline_coord(by, start_y, end_y, ay, lin, i, s);
      e.fin = (i == s);
      expected_samples.push_back(e);
    end
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    sample_t e;
    if (!rst) begin
      if (in_valid && !in_stall) predict_segment();
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) report("unexpected transfer", 1, 0);
        else begin
          e = expected_samples.pop_front();
          if (point_x !== e.x) report("point_x", point_x, e.x);
          if (point_y !== e.y) report("point_y", point_y, e.y);
          if (last !== e.fin) report("last", last, e.fin);
        end
      end
    end
  end
endmodule

[test/tb.sv]
// Testbench top for the Catmull-Rom segment sampler: stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0;
  logic in_stall, out_valid, last;
  logic signed [15:0] before_x = 0, before_y = 0, start_x = 0, start_y = 0;
  logic signed [15:0] end_x = 0, end_y = 0, after_x = 0, after_y = 0;
  logic has_before = 0, has_after = 0;
  logic signed [24:0] point_x, point_y;
  int errors, pending, idle_cycles;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  catmull_rom_segment_sampler dut (.*);
  crs_checker chk (.*);

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 120) : $urandom_range(0, 3);
  endfunction

  function automatic logic [15:0] pick_coord(logic [15:0] near);
    case ($urandom_range(0, 3))
      0: return 16'($urandom());
      1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return near + 16'($signed($urandom_range(0, 60)) - 30);
    endcase
  endfunction

  task automatic send(logic [15:0] bx, by, sx, sy, ex, ey, ax, ay, logic hb, ha);
    int gap;
    before_x <= bx; before_y <= by; start_x <= sx; start_y <= sy;
    end_x <= ex; end_y <= ey; after_x <= ax; after_y <= ay;
    has_before <= hb; has_after <= ha;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    gap = gap_len();
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // receiver stalls, with calm stretches
  initial begin
    bit calm;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) == 0) calm = !calm;
      if (!calm && $urandom_range(0, 40) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(10, 80)) @(posedge clk);
      end else begin
        out_stall <= calm ? 0 : ($urandom_range(0, 3) == 0);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [15:0] sx, sy;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(5, 5, 10, 10, 10, 10, 3, 3, 1, 1);
    send(0, 0, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 0, 0, 0, 0);
    send(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
         16'h8000, 16'h7fff, 1, 1);
    send(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
         16'h7fff, 16'h8000, 1, 1);
    send(16'hffff, 16'hffff, 0, 0, 3, 4, 16'hffff, 16'hffff, 1, 0);
    send(100, 100, 0, 0, 3, 4, 200, 16'hff00, 0, 1);
    send(16'h5555, 16'haaaa, 1, 1, 13, 6, 16'haaaa, 16'h5555, 0, 0);
    send(0, 0, 0, 0, 24, 7, 0, 0, 1, 1);
    send(0, 0, 0, 0, 25, 0, 0, 0, 1, 1);
    send(0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    send(0, 0, 7, 7, 7, 7, 16'h8000, 16'h7fff, 1, 1);
    for (int n = 0; n < 270; n++) begin
      sx = 16'($urandom());
      sy = 16'($urandom());
      send(pick_coord(sx), pick_coord(sy), sx, sy, pick_coord(sx), pick_coord(sy),
           pick_coord(sx), pick_coord(sy), 1'($urandom_range(0, 1)),
           1'($urandom_range(0, 1)));
    end
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

[files.f]
sv/crs_pkg.sv
sv/crs_div.sv
sv/crs_front.sv
sv/crs_fifo.sv
sv/crs_back.sv
sv/catmull_rom_segment_sampler.sv
test/crs_checker.sv
test/tb.sv
